[rtl/format_specifier_parser_macros.svh]
`ifndef FORMAT_SPECIFIER_PARSER_MACROS_SVH
`define FORMAT_SPECIFIER_PARSER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define FSP_ASSERT_IMM(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fsp assertion failed");

// Next-cycle implication, checked out of reset.
`define FSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fsp assertion failed");

`endif

[rtl/fsp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package fsp_pkg;

    localparam int WIDTH_BITS = 16;
    localparam logic [15:0] WIDTH_LIMIT =
        (WIDTH_BITS >= 16) ? 16'hFFFF : 16'((64'd1 << WIDTH_BITS) - 64'd1);

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_PCT    = 2'd1;
    localparam logic [1:0] ST_NO_CONV   = 2'd2;
    localparam logic [1:0] ST_UNSUP     = 2'd3;

    localparam logic [3:0] MOD_NONE = 4'd0;
    localparam logic [3:0] MOD_HH   = 4'd1;
    localparam logic [3:0] MOD_H    = 4'd2;
    localparam logic [3:0] MOD_L    = 4'd3;
    localparam logic [3:0] MOD_LL   = 4'd4;
    localparam logic [3:0] MOD_BIGL = 4'd5;
    localparam logic [3:0] MOD_J    = 4'd6;
    localparam logic [3:0] MOD_Z    = 4'd7;
    localparam logic [3:0] MOD_T    = 4'd8;

    localparam logic [4:0] TY_SCHAR  = 5'd0;
    localparam logic [4:0] TY_UCHAR  = 5'd5;
    localparam logic [4:0] TY_FLOAT  = 5'd10;
    localparam logic [4:0] TY_DOUBLE = 5'd11;
    localparam logic [4:0] TY_LDBL   = 5'd12;
    localparam logic [4:0] TY_CHAR   = 5'd13;
    localparam logic [4:0] TY_WCHAR  = 5'd14;
    localparam logic [4:0] TY_STR    = 5'd15;
    localparam logic [4:0] TY_WSTR   = 5'd16;
    localparam logic [4:0] TY_PTR    = 5'd17;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_H       = 8'h68;
    localparam logic [7:0] CH_L       = 8'h6C;
    localparam logic [7:0] CH_BIGL    = 8'h4C;
    localparam logic [7:0] CH_J       = 8'h6A;
    localparam logic [7:0] CH_Z       = 8'h7A;
    localparam logic [7:0] CH_T       = 8'h74;
    localparam logic [7:0] CH_P       = 8'h70;
    localparam logic [7:0] CH_D       = 8'h64;
    localparam logic [7:0] CH_I       = 8'h69;
    localparam logic [7:0] CH_O       = 8'h6F;
    localparam logic [7:0] CH_U       = 8'h75;
    localparam logic [7:0] CH_X       = 8'h78;
    localparam logic [7:0] CH_BIGX    = 8'h58;
    localparam logic [7:0] CH_E       = 8'h65;
    localparam logic [7:0] CH_BIGE    = 8'h45;
    localparam logic [7:0] CH_G       = 8'h67;
    localparam logic [7:0] CH_BIGG    = 8'h47;
    localparam logic [7:0] CH_A       = 8'h61;
    localparam logic [7:0] CH_BIGA    = 8'h41;
    localparam logic [7:0] CH_F       = 8'h66;
    localparam logic [7:0] CH_BIGF    = 8'h46;
    localparam logic [7:0] CH_C       = 8'h63;
    localparam logic [7:0] CH_S       = 8'h73;

    typedef struct packed {
        logic [1:0]  status;
        logic        width_given;
        logic [15:0] field_width;
        logic        width_overflow;
        logic [3:0]  modifier_code;
        logic [7:0]  conversion_char;
        logic [4:0]  type_code;
    } t_result;

    // {supported, type code}
    function automatic logic [5:0] type_of(input logic [7:0] conv, input logic [3:0] mods);
        logic [4:0] base;
        logic       intlike;
        logic [5:0] r;
        base    = TY_SCHAR;
        intlike = 1'b0;
        r       = 6'd0;
        case (conv) inside
            CH_D, CH_I: begin
                base    = TY_SCHAR;
                intlike = 1'b1;
            end
            CH_O, CH_U, CH_X, CH_BIGX: begin
                base    = TY_UCHAR;
                intlike = 1'b1;
            end
            CH_E, CH_BIGE, CH_G, CH_BIGG, CH_A, CH_BIGA, CH_F, CH_BIGF: begin
                if (mods == MOD_NONE)      r = {1'b1, TY_FLOAT};
                else if (mods == MOD_L)    r = {1'b1, TY_DOUBLE};
                else if (mods == MOD_BIGL) r = {1'b1, TY_LDBL};
            end
            CH_C: begin
                if (mods == MOD_NONE)   r = {1'b1, TY_CHAR};
                else if (mods == MOD_L) r = {1'b1, TY_WCHAR};
            end
            CH_S: begin
                if (mods == MOD_NONE)   r = {1'b1, TY_STR};
                else if (mods == MOD_L) r = {1'b1, TY_WSTR};
            end
            CH_P: begin
                r = {1'b1, TY_PTR};
            end
            default: begin
                r = 6'd0;
            end
        endcase
        if (intlike) begin
            case (mods)
                MOD_HH:   r = {1'b1, base};
                MOD_H:    r = {1'b1, base + 5'd1};
                MOD_NONE: r = {1'b1, base + 5'd2};
                MOD_L:    r = {1'b1, base + 5'd3};
                MOD_LL:   r = {1'b1, base + 5'd4};
                default:  r = 6'd0;
            endcase
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/fsp_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface fsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] spec_byte;
    logic       spec_end;

    modport source (output valid, output spec_byte, output spec_end, input ready);
    modport sink   (input valid, input spec_byte, input spec_end, output ready);
endinterface

interface fsp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        width_given;
    logic [15:0] field_width;
    logic        width_overflow;
    logic [3:0]  modifier_code;
    logic [7:0]  conversion_char;
    logic [4:0]  type_code;

    modport source (output valid, output status, output width_given, output field_width,
                    output width_overflow, output modifier_code, output conversion_char,
                    output type_code, input ready);
    modport sink   (input valid, input status, input width_given, input field_width,
                    input width_overflow, input modifier_code, input conversion_char,
                    input type_code, output ready);
endinterface

`default_nettype wire

[rtl/format_specifier_parser.sv]
// A result is registered in the output register, or in the skid register if output is stalled.
// Throughput: one item per cycle while the skid register is empty; the parse state updates in one pass per byte.
// A skid register behind the output register keeps input open while one result waits.
// Reset (i_rst_n low, synchronous) returns the parser to expect-percent and
// empties the output and skid registers.
`timescale 1ns / 1ps
`default_nettype none

`include "format_specifier_parser_macros.svh"

module format_specifier_parser
    import fsp_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    fsp_in_if.sink     i_in,
    fsp_out_if.source  o_out
);

    localparam logic [2:0] PH_PERCENT = 3'd0;
    localparam logic [2:0] PH_WIDTH   = 3'd1;
    localparam logic [2:0] PH_AFTER_H = 3'd2;
    localparam logic [2:0] PH_AFTER_L = 3'd3;
    localparam logic [2:0] PH_CONV    = 3'd4;
    localparam logic [2:0] PH_SKIP    = 3'd5;

    logic [2:0]  r_phase, n_phase;
    logic [15:0] r_accum, n_accum;
    logic        r_seen, n_seen;
    logic        r_ovf, n_ovf;
    logic [3:0]  r_mod, n_mod;

    logic        r_out_valid, r_skid_valid;
    t_result     r_out, r_skid;

    logic [7:0]  in_byte;
    logic        in_last;
    logic        acc;
    logic        out_take;

    logic [2:0]  upd_phase;
    logic [15:0] upd_accum;
    logic        upd_seen, upd_ovf;
    logic [3:0]  upd_mod;
    logic        res_valid;
    logic [1:0]  res_status;
    logic [7:0]  res_conv;
    logic [4:0]  res_type;
    logic [5:0]  tc;
    logic [3:0]  digit;
    logic [19:0] wsum;
    t_result     res;

    assign in_byte  = i_in.spec_byte;
    assign in_last  = i_in.spec_end;
    assign i_in.ready = !r_skid_valid;
    assign acc      = i_in.valid && !r_skid_valid;
    assign out_take = r_out_valid && o_out.ready;

    // low nibble of an ASCII digit is its value
    assign digit = in_byte[3:0];
    assign wsum  = {1'b0, r_accum, 3'b000} + {3'b000, r_accum, 1'b0} + {16'd0, digit};
    assign tc    = type_of(in_byte, r_mod);

    always_comb begin
        upd_phase  = r_phase;
        upd_accum  = r_accum;
        upd_seen   = r_seen;
        upd_ovf    = r_ovf;
        upd_mod    = r_mod;
        res_valid  = 1'b0;
        res_status = ST_OK;
        res_conv   = 8'd0;
        res_type   = 5'd0;
        case (r_phase)
            PH_PERCENT: begin
                if (in_byte != CH_PERCENT) begin
                    res_valid  = 1'b1;
                    res_status = ST_NO_PCT;
                end else if (in_last) begin
                    res_valid  = 1'b1;
                    res_status = ST_NO_CONV;
                end else begin
                    upd_phase = PH_WIDTH;
                end
            end
            PH_WIDTH: begin
                if (in_byte inside {[CH_ZERO:CH_NINE]}) begin
                    upd_seen = 1'b1;
                    if (wsum > {4'd0, WIDTH_LIMIT}) begin
                        upd_accum = WIDTH_LIMIT;
                        upd_ovf   = 1'b1;
                    end else begin
                        upd_accum = wsum[15:0];
                    end
                end else begin
                    case (in_byte)
                        CH_H: begin
                            upd_mod   = MOD_H;
                            upd_phase = PH_AFTER_H;
                        end
                        CH_L: begin
                            upd_mod   = MOD_L;
                            upd_phase = PH_AFTER_L;
                        end
                        CH_BIGL: begin
                            upd_mod   = MOD_BIGL;
                            upd_phase = PH_CONV;
                        end
                        CH_J: begin
                            upd_mod   = MOD_J;
                            upd_phase = PH_CONV;
                        end
                        CH_Z: begin
                            upd_mod   = MOD_Z;
                            upd_phase = PH_CONV;
                        end
                        CH_T: begin
                            upd_mod   = MOD_T;
                            upd_phase = PH_CONV;
                        end
                        default: begin
                            res_valid  = 1'b1;
                            res_conv   = in_byte;
                            res_status = tc[5] ? ST_OK : ST_UNSUP;
                            res_type   = tc[5] ? tc[4:0] : 5'd0;
                        end
                    endcase
                end
                if (!res_valid && in_last) begin
                    res_valid  = 1'b1;
                    res_status = ST_NO_CONV;
                end
            end
            PH_AFTER_H, PH_AFTER_L: begin
                if (r_phase == PH_AFTER_H && in_byte == CH_H) begin
                    upd_mod   = MOD_HH;
                    upd_phase = PH_CONV;
                    res_valid  = in_last;
                    res_status = ST_NO_CONV;
                end else if (r_phase == PH_AFTER_L && in_byte == CH_L) begin
                    upd_mod   = MOD_LL;
                    upd_phase = PH_CONV;
                    res_valid  = in_last;
                    res_status = ST_NO_CONV;
                end else begin
                    res_valid  = 1'b1;
                    res_conv   = in_byte;
                    res_status = tc[5] ? ST_OK : ST_UNSUP;
                    res_type   = tc[5] ? tc[4:0] : 5'd0;
                end
            end
            PH_CONV: begin
                res_valid  = 1'b1;
                res_conv   = in_byte;
                res_status = tc[5] ? ST_OK : ST_UNSUP;
                res_type   = tc[5] ? tc[4:0] : 5'd0;
            end
            default: begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_comb begin
        res.status          = res_status;
        res.width_given     = upd_seen;
        res.field_width     = upd_accum;
        res.width_overflow  = upd_ovf;
        res.modifier_code   = upd_mod;
        res.conversion_char = res_conv;
        res.type_code       = res_type;
    end

    always_comb begin
        if (in_last) begin
            n_phase = PH_PERCENT;
            n_accum = 16'd0;
            n_seen  = 1'b0;
            n_ovf   = 1'b0;
            n_mod   = MOD_NONE;
        end else begin
            n_phase = res_valid ? PH_SKIP : upd_phase;
            n_accum = upd_accum;
            n_seen  = upd_seen;
            n_ovf   = upd_ovf;
            n_mod   = upd_mod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PERCENT;
            r_accum <= 16'd0;
            r_seen  <= 1'b0;
            r_ovf   <= 1'b0;
            r_mod   <= MOD_NONE;
        end else if (acc) begin
            r_phase <= n_phase;
            r_accum <= n_accum;
            r_seen  <= n_seen;
            r_ovf   <= n_ovf;
            r_mod   <= n_mod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_out_valid && !out_take) begin
            if (acc && res_valid) begin
                r_skid_valid <= 1'b1;
            end
        end else if (r_skid_valid) begin
            r_out_valid  <= 1'b1;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid <= acc && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_out_valid && !out_take) begin
            if (acc && res_valid) begin
                r_skid <= res;
            end
        end else if (r_skid_valid) begin
            r_out <= r_skid;
        end else if (acc && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.status          = r_out.status;
    assign o_out.width_given     = r_out.width_given;
    assign o_out.field_width     = r_out.field_width;
    assign o_out.width_overflow  = r_out.width_overflow;
    assign o_out.modifier_code   = r_out.modifier_code;
    assign o_out.conversion_char = r_out.conversion_char;
    assign o_out.type_code       = r_out.type_code;

    `FSP_ASSERT_IMM(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `FSP_ASSERT_NEXT(a_end_clears, i_clk, i_rst_n, acc && in_last,
        r_phase == PH_PERCENT && r_accum == 16'd0 && r_mod == MOD_NONE && !r_seen && !r_ovf)
    `FSP_ASSERT_NEXT(a_stall_to_skid, i_clk, i_rst_n,
        acc && res_valid && r_out_valid && !o_out.ready, r_skid_valid)
    `FSP_ASSERT_IMM(a_ok_has_conv, i_clk, i_rst_n, r_out_valid && r_out.status == ST_OK,
        r_out.conversion_char != 8'd0 && r_out.type_code <= TY_PTR)

endmodule

`default_nettype wire

[sim/fsp_checker.sv]
`timescale 1ns / 1ps

module fsp_checker
    import fsp_pkg::*;
(
    input  wire i_clk,
    input  wire i_rst_n,
    fsp_in_if   i_in_mon,
    fsp_out_if  i_out_mon,
    output int  o_fail_count,
    output int  o_pending,
    output int  o_checked
);

    typedef enum logic [2:0] {
        SEEK_PERCENT,
        IN_WIDTH,
        AFTER_H,
        AFTER_L,
        WANT_CONV,
        SKIP_TAIL
    } t_phase;

    t_phase      phase;
    logic [15:0] width_acc;
    logic        width_hit;
    logic        width_sat;
    logic [3:0]  mod_held;
    t_result     spec_results_q[$];
    int          fail_total   = 0;
    int          result_total = 0;

    function automatic void restart_spec();
        phase     = SEEK_PERCENT;
        width_acc = '0;
        width_hit = 1'b0;
        width_sat = 1'b0;
        mod_held  = MOD_NONE;
    endfunction

    // returns 1 and the argument type when the pair is supported
    function automatic logic arg_type_for(input logic [7:0] conv, input logic [3:0] mods,
                                          output logic [4:0] ty);
        logic [4:0] base;
        base = TY_SCHAR;
        ty   = '0;
        case (conv)
            CH_D, CH_I: base = TY_SCHAR;
            CH_O, CH_U, CH_X, CH_BIGX: base = TY_UCHAR;
            CH_E, CH_BIGE, CH_G, CH_BIGG, CH_A, CH_BIGA, CH_F, CH_BIGF: begin
                case (mods)
                    MOD_NONE: ty = TY_FLOAT;
                    MOD_L:    ty = TY_DOUBLE;
                    MOD_BIGL: ty = TY_LDBL;
                    default:  return 1'b0;
                endcase
                return 1'b1;
            end
            CH_C: begin
                case (mods)
                    MOD_NONE: ty = TY_CHAR;
                    MOD_L:    ty = TY_WCHAR;
                    default:  return 1'b0;
                endcase
                return 1'b1;
            end
            CH_S: begin
                case (mods)
                    MOD_NONE: ty = TY_STR;
                    MOD_L:    ty = TY_WSTR;
                    default:  return 1'b0;
                endcase
                return 1'b1;
            end
            CH_P: begin
                ty = TY_PTR;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
        // integer conversions: hh, h, none, l, ll in rank order
        case (mods)
            MOD_HH:   ty = base;
            MOD_H:    ty = base + 5'd1;
            MOD_NONE: ty = base + 5'd2;
            MOD_L:    ty = base + 5'd3;
            MOD_LL:   ty = base + 5'd4;
            default:  return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic void push_result(input logic [1:0] st, input logic [7:0] conv,
                                        input logic [4:0] ty);
        t_result r;
        r.status          = st;
        r.width_given     = width_hit;
        r.field_width     = width_acc;
        r.width_overflow  = width_sat;
        r.modifier_code   = mod_held;
        r.conversion_char = conv;
        r.type_code       = ty;
        spec_results_q.push_back(r);
    endfunction

    function automatic void conclude_conv(input logic [7:0] conv);
        logic [4:0] ty;
        if (arg_type_for(conv, mod_held, ty)) push_result(ST_OK, conv, ty);
        else push_result(ST_UNSUP, conv, '0);
    endfunction

    function automatic void parse_spec_byte(input logic [7:0] b, input logic last);
        logic        done;
        logic [31:0] grown;
        done = 1'b0;
        case (phase)
            SEEK_PERCENT: begin
                // all width/modifier fields are clear in this phase
                if (b != CH_PERCENT) begin
                    push_result(ST_NO_PCT, '0, '0);
                    done = 1'b1;
                end else if (last) begin
                    push_result(ST_NO_CONV, '0, '0);
                    done = 1'b1;
                end else begin
                    phase = IN_WIDTH;
                end
            end
            IN_WIDTH: begin
                if (b >= CH_ZERO && b <= CH_NINE) begin
                    grown = 32'(width_acc) * 32'd10 + 32'(b - CH_ZERO);
                    width_hit = 1'b1;
                    if (grown > 32'(WIDTH_LIMIT)) begin
                        grown     = 32'(WIDTH_LIMIT);
                        width_sat = 1'b1;
                    end
                    width_acc = grown[15:0];
                    if (last) begin
                        push_result(ST_NO_CONV, '0, '0);
                        done = 1'b1;
                    end
                end else begin
                    case (b)
                        CH_H: begin
                            mod_held = MOD_H;
                            phase    = AFTER_H;
                        end
                        CH_L: begin
                            mod_held = MOD_L;
                            phase    = AFTER_L;
                        end
                        CH_BIGL: begin
                            mod_held = MOD_BIGL;
                            phase    = WANT_CONV;
                        end
                        CH_J: begin
                            mod_held = MOD_J;
                            phase    = WANT_CONV;
                        end
                        CH_Z: begin
                            mod_held = MOD_Z;
                            phase    = WANT_CONV;
                        end
                        CH_T: begin
                            mod_held = MOD_T;
                            phase    = WANT_CONV;
                        end
                        default: begin
                            conclude_conv(b);
                            done = 1'b1;
                        end
                    endcase
                    if (!done && last) begin
                        push_result(ST_NO_CONV, '0, '0);
                        done = 1'b1;
                    end
                end
            end
            AFTER_H, AFTER_L: begin
                if ((phase == AFTER_H && b == CH_H) || (phase == AFTER_L && b == CH_L)) begin
                    mod_held = (phase == AFTER_H) ? MOD_HH : MOD_LL;
                    phase    = WANT_CONV;
                    if (last) begin
                        push_result(ST_NO_CONV, '0, '0);
                        done = 1'b1;
                    end
                end else begin
                    conclude_conv(b);
                    done = 1'b1;
                end
            end
            WANT_CONV: begin
                conclude_conv(b);
                done = 1'b1;
            end
            default: ;
        endcase
        if (last) restart_spec();
        else if (done) phase = SKIP_TAIL;
    endfunction

    function automatic void check_field(input string fname, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            fail_total++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            restart_spec();
            spec_results_q.delete();
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                got.status          = i_out_mon.status;
                got.width_given     = i_out_mon.width_given;
                got.field_width     = i_out_mon.field_width;
                got.width_overflow  = i_out_mon.width_overflow;
                got.modifier_code   = i_out_mon.modifier_code;
                got.conversion_char = i_out_mon.conversion_char;
                got.type_code       = i_out_mon.type_code;
                result_total++;
                if (spec_results_q.size() == 0) begin
                    fail_total++;
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, got);
                end else begin
                    want = spec_results_q.pop_front();
                    check_field("status", 16'(want.status), 16'(got.status));
                    check_field("width_given", 16'(want.width_given), 16'(got.width_given));
                    check_field("field_width", want.field_width, got.field_width);
                    check_field("width_overflow", 16'(want.width_overflow),
                                16'(got.width_overflow));
                    check_field("modifier_code", 16'(want.modifier_code),
                                16'(got.modifier_code));
                    check_field("conversion_char", 16'(want.conversion_char),
                                16'(got.conversion_char));
                    check_field("type_code", 16'(want.type_code), 16'(got.type_code));
                end
            end
            if (i_in_mon.valid && i_in_mon.ready)
                parse_spec_byte(i_in_mon.spec_byte, i_in_mon.spec_end);
        end
        o_pending    <= spec_results_q.size();
        o_fail_count <= fail_total;
        o_checked    <= result_total;
    end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;
    import fsp_pkg::*;

    localparam int ITEM_TARGET  = 900;
    localparam int HOLD_AT      = 300;
    localparam int PAUSE_AT     = 600;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 20;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   checked;
    int   items_sent = 0;
    int   specs_sent = 0;
    int   burst_left = 0;
    int   hold_req   = 0;
    int   hold_seen;
    int   hold_left;
    int   rx_cycle;
    logic [7:0] spec_q[$];
    logic [7:0] conv_pool [18] = '{CH_D, CH_I, CH_O, CH_U, CH_X, CH_BIGX, CH_E, CH_BIGE,
                                   CH_G, CH_BIGG, CH_A, CH_BIGA, CH_F, CH_BIGF, CH_C,
                                   CH_S, CH_P, CH_PERCENT};

    fsp_in_if  in_ch();
    fsp_out_if out_ch();

    format_specifier_parser u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    fsp_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side: rotating stall modes, plus one long hold on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            hold_seen    <= 0;
            hold_left    <= 0;
            rx_cycle     <= 0;
        end else begin
            rx_cycle <= rx_cycle + 1;
            if (hold_seen != hold_req) begin
                hold_seen    <= hold_req;
                hold_left    <= HOLD_CYCLES;
                out_ch.ready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left    <= hold_left - 1;
                out_ch.ready <= 1'b0;
            end else begin
                case (rx_cycle[8:7])
                    2'd0:    out_ch.ready <= 1'b1;
                    2'd1:    out_ch.ready <= 1'($urandom_range(0, 1));
                    2'd2:    out_ch.ready <= (rx_cycle[2:0] == 3'd0);
                    default: out_ch.ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle = 0;
            else
                idle++;
        end
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("format_specifier_parser test failed");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        logic took;
        int   gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        in_ch.valid     <= 1'b1;
        in_ch.spec_byte <= b;
        in_ch.spec_end  <= last;
        // ready is settled by the falling edge
        do begin
            @(negedge i_clk);
            took = in_ch.ready;
            @(posedge i_clk);
        end while (!took);
        items_sent++;
    endtask

    task automatic send_spec();
        foreach (spec_q[k]) send_byte(spec_q[k], k == spec_q.size() - 1);
        specs_sent++;
    endtask

    task automatic send_text(input string s);
        spec_q.delete();
        for (int k = 0; k < s.len(); k++) spec_q.push_back(s[k]);
        send_spec();
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic build_random_spec();
        int         pick;
        int         n;
        string      digits;
        logic [7:0] b;
        spec_q.delete();
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            n = $urandom_range(1, 5);
            repeat (n) spec_q.push_back(8'($urandom_range(0, 255)));
            return;
        end
        if (pick < 16) begin
            do b = 8'($urandom_range(0, 255)); while (b == CH_PERCENT);
            spec_q.push_back(b);
        end else begin
            spec_q.push_back(CH_PERCENT);
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3: ;
            4, 5, 6, 7: begin
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
                repeat (n) spec_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            end
            default: begin
                case ($urandom_range(0, 3))
                    0:       digits = "65535";
                    1:       digits = "65536";
                    2:       digits = $sformatf("%0d", $urandom_range(6553, 65535));
                    default: digits = $sformatf("%0d", $urandom_range(65536, 999999));
                endcase
                for (int k = 0; k < digits.len(); k++) spec_q.push_back(digits[k]);
            end
        endcase
        case ($urandom_range(0, 11))
            0: begin
                spec_q.push_back(CH_H);
                spec_q.push_back(CH_H);
            end
            1: spec_q.push_back(CH_H);
            2: spec_q.push_back(CH_L);
            3: begin
                spec_q.push_back(CH_L);
                spec_q.push_back(CH_L);
            end
            4: spec_q.push_back(CH_BIGL);
            5: spec_q.push_back(CH_J);
            6: spec_q.push_back(CH_Z);
            7: spec_q.push_back(CH_T);
            default: ;
        endcase
        if ($urandom_range(0, 6) == 0) spec_q.push_back(8'($urandom_range(0, 255)));
        else spec_q.push_back(conv_pool[$urandom_range(0, 17)]);
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            n = $urandom_range(1, spec_q.size() - 1);
            while (spec_q.size() > n) void'(spec_q.pop_back());
        end else if (pick < 32) begin
            n = $urandom_range(1, 3);
            repeat (n) spec_q.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin : stim
        bit paused;
        paused          = 1'b0;
        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.spec_byte = 8'd0;
        in_ch.spec_end  = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_text("%d");
        send_text("\377");
        send_text("%");
        send_text("%5");
        send_text("%ll");
        send_text("%%");
        send_text("%hf");
        send_text("%zp");
        send_text("%65536x");
        send_text("%cQ");

        while (items_sent < ITEM_TARGET) begin
            if (hold_req == 0 && items_sent >= HOLD_AT) hold_req <= hold_req + 1;
            if (!paused && items_sent >= PAUSE_AT) begin
                wait_drained();
                paused = 1'b1;
            end
            build_random_spec();
            send_spec();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Covered %0d bytes in %0d specifiers, %0d results compared,", items_sent,
                 specs_sent, checked);
        $display("with one long output hold and one full drain mid-run.");
        if (fail_count == 0 && pending == 0) $display("format_specifier_parser test passed");
        else $display("format_specifier_parser test failed");
        $finish;
    end

endmodule
